FILE: src/fpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and tables for the FSK phase discriminator.
package fpd_pkg;

  // Frame geometry
  localparam int FRAME_LEN = 16384;
  localparam int CNT_W     = $clog2(FRAME_LEN);
  localparam int IDX_W     = 14;

  // Configuration
  localparam int                 THR_W          = 16;
  localparam logic [THR_W-1:0]   HOLD_THR_RESET = 16'd5461;
  localparam int                 PADDR_W        = 3;
  localparam logic               REG_HOLD_THR   = 1'b0;

  // CORDIC engines
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int PX_W         = 35;   // phase engine x/y
  localparam int CX_W         = 34;   // cosine engine x/y
  localparam int CZ_W         = 33;   // cosine engine angle
  localparam logic [31:0] COS_GAIN_INIT = 32'd652032874;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // Window angle increment per frame position: 2^32 / (FRAME_LEN-1)
  localparam longint unsigned THETA_STEP = (64'd1 << 32) / (FRAME_LEN - 1);
  localparam longint unsigned THETA_REM  = (64'd1 << 32) % (FRAME_LEN - 1);

  // Hamming coefficient: floor((54*2^30 - 46*c + 50*2^15) / (100*2^15))
  localparam int     NUM_W       = 40;
  localparam longint WIN_BIAS    = 54 * (64'sd1 <<< 30) + 50 * (64'sd1 <<< 15);
  localparam int     M_W         = 22;
  localparam int     RECIP_SHIFT = 29;
  localparam int     RECIP       = ((1 << RECIP_SHIFT) + 99) / 100;
  localparam int     RECIP_W     = 23;
  localparam int     W_W         = 16;
  localparam logic [W_W-1:0] W_MAX = 16'd32768;
  localparam int     PROD_W      = 33;

  typedef struct packed {
    logic signed [15:0] sample_i;
    logic signed [15:0] sample_q;
  } fpd_in_t;

  typedef struct packed {
    logic signed [15:0] freq_out;
    logic [IDX_W-1:0]   out_index;
    logic               frame_last;
  } fpd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_DIFF,
    ST_WIN_M,
    ST_WIN_Q,
    ST_MUL,
    ST_EMIT
  } fpd_state_t;

  typedef struct packed {
    logic              load;
    logic              iter;
    logic [STEP_W-1:0] step;
    logic              diff;
    logic              win_m;
    logic              win_q;
    logic              mul;
    logic              emit;
    logic              second;
  } fpd_cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic pos_last;
    logic out_free;
  } fpd_stat_t;

endpackage

FILE: src/fsk_phase_discriminator_window_core.sv
`timescale 1ns / 1ps
// Top level of the FSK phase-difference discriminator with Hamming window.
//
//   port group   direction  handshake          payload
//   in_*         sink       in_valid/in_stall  fpd_in_t  {sample_i, sample_q}
//   out_*        source     out_valid/out_stall fpd_out_t {freq_out, out_index, frame_last}
//   p*           APB slave  psel/penable/pready hold_threshold at byte address 0
//
// Flow: per sample, the 16-step CORDIC iteration of both engines, then the
//   difference, window, multiply and emit steps; a frame's first sample stops
//   after the difference, and its last runs CORDIC and window again for two results.
// Reset: synchronous, active low; frame position, previous angle, held
//   difference and the threshold (5461) return to their reset values.
// Stalls: in_stall is high from the accepting edge until the sequencer is idle
//   again; a finished result waits in the output register while the next
//   sample is taken in, and the emit step waits only while that register
//   still holds an untaken transfer.
module fsk_phase_discriminator_window_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // sample input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fpd_pkg::fpd_in_t            in_data,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output fpd_pkg::fpd_out_t           out_data,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fpd_pkg::*;

  fpd_cmd_t         cmd;
  fpd_stat_t        stat;
  logic [THR_W-1:0] hold_thr_r;
  logic             reg_sel;
  logic             cfg_wr;

  // Register decode: word index sits above the byte-lane bits.
  assign reg_sel = paddr[PADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_thr_r <= HOLD_THR_RESET;
    end else if (cfg_wr && (reg_sel == REG_HOLD_THR)) begin
      hold_thr_r <= pwdata[THR_W-1:0];
    end
  end

  assign prdata = (reg_sel == REG_HOLD_THR) ? {16'b0, hold_thr_r} : 32'b0;

  // Sequencer: one item at a time, accept only from idle
  fpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic, frame state and the output transfer register
  fpd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .hold_thr  (hold_thr_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: src/fpd_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the discriminator: steps the CORDICs, window and result emit.
module fpd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fpd_pkg::fpd_stat_t stat,
  output fpd_pkg::fpd_cmd_t  cmd
);
  import fpd_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

  fpd_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              second_r, second_nxt;
  logic              last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      second_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      second_r <= second_nxt;
      last_r   <= last_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    second_nxt = second_r;
    last_nxt   = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt  = ST_CORDIC;
          step_nxt   = '0;
          second_nxt = 1'b0;
        end
      end
      ST_CORDIC: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = second_r ? ST_WIN_M : ST_DIFF;
        end
      end
      ST_DIFF: begin
        last_nxt  = stat.pos_last;
        state_nxt = stat.pos_zero ? ST_IDLE : ST_WIN_M;
      end
      ST_WIN_M: state_nxt = ST_WIN_Q;
      ST_WIN_Q: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free) begin
          if (last_r && !second_r) begin
            // repeat of the last difference with the final coefficient
            second_nxt = 1'b1;
            step_nxt   = '0;
            state_nxt  = ST_CORDIC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    cmd.step   = step_r;
    cmd.second = second_r;
    in_stall   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CORDIC: cmd.iter  = 1'b1;
      ST_DIFF:   cmd.diff  = 1'b1;
      ST_WIN_M:  cmd.win_m = 1'b1;
      ST_WIN_Q:  cmd.win_q = 1'b1;
      ST_MUL:    cmd.mul   = 1'b1;
      ST_EMIT: begin
        cmd.emit = stat.out_free;
        cmd.load = stat.out_free && last_r && !second_r;
      end
      default: ;
    endcase
  end

endmodule

FILE: src/fpd_datapath.sv
`timescale 1ns / 1ps
// Datapath: phase and cosine CORDICs, hold logic, window and output register.
module fpd_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fpd_pkg::fpd_cmd_t         cmd,
  output fpd_pkg::fpd_stat_t        stat,
  input  fpd_pkg::fpd_in_t          in_data,
  input  logic [fpd_pkg::THR_W-1:0] hold_thr,
  input  logic                      out_stall,
  output logic                      out_valid,
  output fpd_pkg::fpd_out_t         out_data
);
  import fpd_pkg::*;

  // phase engine
  logic signed [PX_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [31:0]            pz_r, pz_nxt;
  logic                   pzero_r, pzero_nxt;
  // cosine engine
  logic signed [CX_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [CZ_W-1:0] cz_r, cz_nxt;
  logic                   cneg_r, cneg_nxt;
  // frame state
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [15:0]            prev_angle_r, prev_angle_nxt;
  logic signed [15:0]     held_r, held_nxt;
  logic [31:0]            th_r, th_nxt, th_prev_r, th_prev_nxt;
  logic [CNT_W-1:0]       th_rem_r, th_rem_nxt;
  logic [CNT_W-1:0]       item_pos_r, item_pos_nxt;
  // window pipeline
  logic [M_W-1:0]           m_r, m_nxt;
  logic [W_W-1:0]           w_r, w_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  // result register
  logic     out_valid_r, out_valid_nxt;
  fpd_out_t out_data_r, out_data_nxt;

  // combinational helpers
  logic signed [PX_W-1:0]   si_ext, sq_ext, px_shr, py_shr;
  logic signed [CX_W-1:0]   cx_shr, cy_shr, c_val;
  logic signed [CZ_W-1:0]   atan_ext;
  logic [31:0]              th_fold, ang_sum;
  logic                     fold;
  logic [15:0]              angle;
  logic signed [15:0]       raw, kept;
  logic signed [16:0]       raw_ext;
  logic [16:0]              mag;
  logic                     hold;
  logic [CNT_W:0]           rem_sum;
  logic                     rem_carry;
  logic [31:0]              th_adv;
  logic signed [NUM_W-1:0]  num, c_ext;
  logic [M_W+RECIP_W-1:0]   q_prod;
  logic [15:0]              q;
  logic signed [PROD_W-1:0] rnd, sh;
  logic signed [15:0]       sat;
  logic [CNT_W-1:0]         pos_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      prev_angle_r <= '0;
      held_r       <= '0;
      th_r         <= '0;
      th_rem_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      prev_angle_r <= prev_angle_nxt;
      held_r       <= held_nxt;
      th_r         <= th_nxt;
      th_rem_r     <= th_rem_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pz_r       <= pz_nxt;
    pzero_r    <= pzero_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    cneg_r     <= cneg_nxt;
    th_prev_r  <= th_prev_nxt;
    item_pos_r <= item_pos_nxt;
    m_r        <= m_nxt;
    w_r        <= w_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    // engine operands
    si_ext   = PX_W'(in_data.sample_i) <<< 16;
    sq_ext   = PX_W'(in_data.sample_q) <<< 16;
    px_shr   = px_r >>> cmd.step;
    py_shr   = py_r >>> cmd.step;
    cx_shr   = cx_r >>> cmd.step;
    cy_shr   = cy_r >>> cmd.step;
    atan_ext = $signed({1'b0, ATAN_TAB[cmd.step]});
    fold     = (th_prev_r[31:30] == 2'b01) || (th_prev_r[31:30] == 2'b10);
    th_fold  = fold ? th_prev_r + 32'h8000_0000 : th_prev_r;

    // phase difference and hold
    ang_sum = pz_r + 32'h0000_8000;
    angle   = pzero_r ? 16'd0 : ang_sum[31:16];
    raw     = $signed(angle - prev_angle_r);
    raw_ext = 17'(raw);
    mag     = raw_ext[16] ? $unsigned(-raw_ext) : $unsigned(raw_ext);
    hold    = (count_r > CNT_W'(1)) && (mag >= {1'b0, hold_thr});
    kept    = hold ? held_r : raw;

    // window angle for the next position, exact floor via remainder
    rem_sum   = {1'b0, th_rem_r} + (CNT_W+1)'(THETA_REM);
    rem_carry = rem_sum >= (CNT_W+1)'(FRAME_LEN - 1);
    th_adv    = th_r + 32'(THETA_STEP) + {31'b0, rem_carry};

    // coefficient arithmetic
    c_val  = cneg_r ? -cx_r : cx_r;
    c_ext  = NUM_W'(c_val);
    num    = NUM_W'(WIN_BIAS) - 40'sd46 * c_ext;
    q_prod = (M_W+RECIP_W)'(m_r) * (M_W+RECIP_W)'(RECIP);
    q      = q_prod[RECIP_SHIFT+15:RECIP_SHIFT];

    // rounding and saturation
    rnd = prod_r + 33'sd16384;
    sh  = rnd >>> 15;
    if (sh > 33'sd32767) begin
      sat = 16'sh7FFF;
    end else if (sh < -33'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sh[15:0];
    end
    pos_m1 = item_pos_r - CNT_W'(1);

    // defaults: hold
    px_nxt         = px_r;
    py_nxt         = py_r;
    pz_nxt         = pz_r;
    pzero_nxt      = pzero_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    cz_nxt         = cz_r;
    cneg_nxt       = cneg_r;
    count_nxt      = count_r;
    prev_angle_nxt = prev_angle_r;
    held_nxt       = held_r;
    th_nxt         = th_r;
    th_rem_nxt     = th_rem_r;
    th_prev_nxt    = th_prev_r;
    item_pos_nxt   = item_pos_r;
    m_nxt          = m_r;
    w_nxt          = w_r;
    prod_nxt       = prod_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;

    if (cmd.load) begin
      pzero_nxt = (in_data.sample_i == 16'sd0) && (in_data.sample_q == 16'sd0);
      if (in_data.sample_i[15]) begin
        px_nxt = -si_ext;
        py_nxt = -sq_ext;
        pz_nxt = 32'h8000_0000;
      end else begin
        px_nxt = si_ext;
        py_nxt = sq_ext;
        pz_nxt = 32'h0000_0000;
      end
      cx_nxt   = CX_W'(COS_GAIN_INIT);
      cy_nxt   = '0;
      cz_nxt   = CZ_W'($signed(th_fold));
      cneg_nxt = fold;
    end

    if (cmd.iter) begin
      // vectoring: drive y toward zero
      if (!py_r[PX_W-1]) begin
        px_nxt = px_r + py_shr;
        py_nxt = py_r - px_shr;
        pz_nxt = pz_r + ATAN_TAB[cmd.step];
      end else begin
        px_nxt = px_r - py_shr;
        py_nxt = py_r + px_shr;
        pz_nxt = pz_r - ATAN_TAB[cmd.step];
      end
      // rotation: drive z toward zero
      if (!cz_r[CZ_W-1]) begin
        cx_nxt = cx_r - cy_shr;
        cy_nxt = cy_r + cx_shr;
        cz_nxt = cz_r - atan_ext;
      end else begin
        cx_nxt = cx_r + cy_shr;
        cy_nxt = cy_r - cx_shr;
        cz_nxt = cz_r + atan_ext;
      end
    end

    if (cmd.diff) begin
      prev_angle_nxt = angle;
      th_prev_nxt    = th_r;
      item_pos_nxt   = count_r;
      if (count_r == '0) begin
        count_nxt  = CNT_W'(1);
        th_nxt     = th_adv;
        th_rem_nxt = rem_carry ? rem_sum[CNT_W-1:0] - CNT_W'(FRAME_LEN - 1)
                               : rem_sum[CNT_W-1:0];
      end else begin
        held_nxt = kept;
        if (count_r == CNT_W'(FRAME_LEN - 1)) begin
          count_nxt  = '0;
          th_nxt     = '0;
          th_rem_nxt = '0;
        end else begin
          count_nxt  = count_r + CNT_W'(1);
          th_nxt     = th_adv;
          th_rem_nxt = rem_carry ? rem_sum[CNT_W-1:0] - CNT_W'(FRAME_LEN - 1)
                                 : rem_sum[CNT_W-1:0];
        end
      end
    end

    if (cmd.win_m) begin
      m_nxt = num[NUM_W-1] ? '0 : num[M_W+14:15];
    end

    if (cmd.win_q) begin
      w_nxt = (q > W_MAX) ? W_MAX : q;
    end

    if (cmd.mul) begin
      prod_nxt = PROD_W'(held_r) * PROD_W'($signed({1'b0, w_r}));
    end

    if (cmd.emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.freq_out   = sat;
      out_data_nxt.out_index  = cmd.second ? IDX_W'(item_pos_r) : IDX_W'(pos_m1);
      out_data_nxt.frame_last = cmd.second;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign stat.pos_zero = (count_r == '0);
  assign stat.pos_last = (count_r == CNT_W'(FRAME_LEN - 1));
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/fpd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the discriminator, bound to the top level.
module fpd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input fpd_pkg::fpd_in_t            in_data,
  input logic                        out_valid,
  input logic                        out_stall,
  input fpd_pkg::fpd_out_t           out_data,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [fpd_pkg::PADDR_W-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);
  import fpd_pkg::*;

  // a held result does not change until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an accepted sample keeps the input stalled on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // the frame end marker only rides on the last frame position
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_last |-> out_data.out_index == IDX_W'(FRAME_LEN - 1))
    else $error("frame_last on wrong index");

  // threshold write is visible on readback
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && !paddr[PADDR_W-1]
    |=> paddr[PADDR_W-1] || (prdata[THR_W-1:0] == $past(pwdata[THR_W-1:0])))
    else $error("threshold readback mismatch");

endmodule

bind fsk_phase_discriminator_window_core fpd_checker u_fpd_checker (.*);

FILE: dv/fsk_phase_discriminator_window_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the FSK phase discriminator with Hamming window.
module fsk_phase_discriminator_window_core_test;
  import fpd_pkg::*;

  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int SETTLE_CYCLES = 64;     // settle time after the last expected result
  localparam int DRAIN_LIMIT   = 20_000;
  localparam int FREEZE_LEN    = 600;    // long receiver hold-off, in cycles
  localparam int PHASE_ITEMS   = 246;
  localparam logic [PADDR_W-1:0] THR_ADDR = PADDR_W'(4 * REG_HOLD_THR);

  // CORDIC arctangent steps, full turn = 2^32
  localparam logic [31:0] TURN_STEP [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // Opening samples: zero, axes, corners, half-turn jumps, tiny steps.
  // Packed as {sample_i, sample_q}.
  localparam logic [31:0] PROBES [24] = '{
    32'h0000_0000, 32'h0000_0000, 32'h7FFF_0000, 32'h0000_7FFF,
    32'h8000_0000, 32'h0000_8000, 32'h7FFF_0000, 32'h8000_0000,
    32'h8000_8000, 32'h7FFF_7FFF, 32'hFFFF_0000, 32'h0000_FFFF,
    32'h0001_0000, 32'h0000_0001, 32'h8000_7FFF, 32'h7FFF_8000,
    32'h0064_0001, 32'h0064_0002, 32'h0064_0003, 32'hFFFF_FFFF,
    32'hFFFF_0001, 32'h8000_FFFF, 32'h8000_0001, 32'h0000_0000
  };

  localparam logic [15:0] EDGE_VALS [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};

  // Predicts the windowed frequency results and checks them in order.
  class freq_scoreboard;
    int                 thr;
    int                 position;
    logic [15:0]        last_angle;
    logic signed [15:0] kept_diff;
    logic [15:0]        coef [FRAME_LEN];
    fpd_out_t           pending [$];
    int                 errors, samples, results, holds, frames;

    function longint hamming_cos(logic [31:0] th);
      longint x, y, nx, z;
      bit     flip;
      int     k;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      // fold into the right half plane
      if (th[31:30] == 2'd1 || th[31:30] == 2'd2) begin
        th = th + 32'h8000_0000;
        flip = 1'b1;
      end
      z = longint'(signed'(th));
      for (k = 0; k < 16; k++) begin
        if (z >= 0) begin
          nx = x - (y >>> k);
          y  = y + (x >>> k);
          z  = z - longint'(TURN_STEP[k]);
        end else begin
          nx = x + (y >>> k);
          y  = y - (x >>> k);
          z  = z + longint'(TURN_STEP[k]);
        end
        x = nx;
      end
      return flip ? -x : x;
    endfunction

    function void power_up();
      longint unsigned th;
      longint          c, num, w;
      int              n;
      thr        = HOLD_THR_RESET;
      position   = 0;
      last_angle = '0;
      kept_diff  = '0;
      for (n = 0; n < FRAME_LEN; n++) begin
        th  = (longint'(n) << 32) / (FRAME_LEN - 1);
        c   = hamming_cos(th[31:0]);
        num = 64'sd57982058496 - 46 * c + 64'sd1638400;
        w   = (num > 0) ? num / 3276800 : 0;
        if (w > 32768) w = 32768;
        coef[n] = w[15:0];
      end
    endfunction

    function logic [15:0] sample_angle(logic signed [15:0] si, logic signed [15:0] sq);
      longint      x, y, nx;
      logic [31:0] z, zr;
      int          k;
      if (si == 0 && sq == 0) return 16'd0;
      x = longint'(si) * 65536;
      y = longint'(sq) * 65536;
      z = 32'd0;
      if (si < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (k = 0; k < 16; k++) begin
        if (y >= 0) begin
          nx = x + (y >>> k);
          y  = y - (x >>> k);
          z  = z + TURN_STEP[k];
        end else begin
          nx = x - (y >>> k);
          y  = y + (x >>> k);
          z  = z - TURN_STEP[k];
        end
        x = nx;
      end
      zr = z + 32'h0000_8000;
      return zr[31:16];
    endfunction

    // kept difference times Q1.15 coefficient, round half up, saturate
    function logic [15:0] windowed(logic signed [15:0] d, int pos);
      longint p, r;
      p = longint'(d) * longint'(coef[pos % FRAME_LEN]);
      r = (p + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void take_sample(fpd_in_t s);
      logic [15:0]        ang, delta;
      logic signed [15:0] raw;
      int                 idx, mag;
      fpd_out_t           r;
      samples++;
      ang = sample_angle(s.sample_i, s.sample_q);
      if (position == 0) begin
        last_angle = ang;
        position = 1;
        return;
      end
      delta = ang - last_angle;
      raw = signed'(delta);
      last_angle = ang;
      idx = position - 1;
      mag = (raw < 0) ? -int'(raw) : int'(raw);
      if (idx >= 1 && mag >= thr) begin
        holds++;
      end else begin
        kept_diff = raw;
      end
      r.freq_out   = windowed(kept_diff, idx);
      r.out_index  = IDX_W'(idx);
      r.frame_last = 1'b0;
      pending.push_back(r);
      if (position >= FRAME_LEN - 1) begin
        // last sample of the frame: repeat the kept value under the final coefficient
        r.freq_out   = windowed(kept_diff, position);
        r.out_index  = IDX_W'(position);
        r.frame_last = 1'b1;
        pending.push_back(r);
        position = 0;
        frames++;
      end else begin
        position++;
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_result(fpd_out_t got);
      fpd_out_t want;
      results++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = pending.pop_front();
        if (got.freq_out !== want.freq_out)
          report_mismatch($sformatf("freq_out %0d, want %0d (index %0d)",
                                    got.freq_out, want.freq_out, want.out_index));
        if (got.out_index !== want.out_index)
          report_mismatch($sformatf("out_index %0d, want %0d", got.out_index, want.out_index));
        if (got.frame_last !== want.frame_last)
          report_mismatch($sformatf("frame_last %b, want %b (index %0d)",
                                    got.frame_last, want.frame_last, want.out_index));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  fpd_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  fpd_out_t            out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [31:0]         pwdata    = '0;
  logic [31:0]         prdata;
  logic                pready;

  freq_scoreboard sb;
  fpd_in_t        last_sample = '0;
  int             tx_idle_pct = 0;
  int             rx_idle_pct = 0;
  int             freeze_req  = 0;   // bumped by the stimulus to ask for a hold-off
  int             freeze_ack  = 0;
  int             freeze_left = 0;
  int             cycle_cnt   = 0;

  fsk_phase_discriminator_window_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stall, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (freeze_req != freeze_ack) begin
      freeze_ack  = freeze_req;
      freeze_left = FREEZE_LEN;
    end
    if (freeze_left > 0) begin
      out_stall <= 1'b1;
      freeze_left--;
    end else begin
      out_stall <= (int'($urandom_range(99)) < rx_idle_pct);
    end
  end

  // Every completed result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_result(out_data);
  end

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Half the time slow drift around the previous sample so that small differences
  // survive the hold; quarter/half turns, rail values and pure noise mixed in.
  function automatic fpd_in_t next_sample(fpd_in_t prior);
    fpd_in_t s;
    int      pick;
    pick = $urandom_range(99);
    s = fpd_in_t'($urandom);
    if (pick < 50) begin
      s.sample_i = clip16(int'(prior.sample_i) + int'($urandom_range(4096)) - 2048);
      s.sample_q = clip16(int'(prior.sample_q) + int'($urandom_range(4096)) - 2048);
    end else if (pick < 58) begin
      s.sample_i = clip16(-int'(prior.sample_q));
      s.sample_q = prior.sample_i;
    end else if (pick < 64) begin
      s.sample_i = clip16(-int'(prior.sample_i));
      s.sample_q = clip16(-int'(prior.sample_q));
    end else if (pick < 74) begin
      s.sample_i = EDGE_VALS[$urandom_range(4)];
      s.sample_q = EDGE_VALS[$urandom_range(4)];
    end
    return s;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input fpd_in_t s);
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    sb.take_sample(s);
    last_sample = s;
    @(negedge clk);
  endtask

  // Drop valid and let every predicted result come out, then let the block settle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random(input int count, input int pause_at, input int freeze_at);
    int n;
    for (n = 0; n < count; n++) begin
      if (n == freeze_at) freeze_req++;
      if (n == pause_at) wait_for_results();
      send_sample(next_sample(last_sample));
    end
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_threshold(input logic [15:0] value);
    logic [31:0] rd;
    wait_for_results();
    // upper data bits carry noise; only the low half is the register
    apb_access(1'b1, THR_ADDR, {16'($urandom), value}, rd);
    apb_access(1'b0, THR_ADDR, 32'd0, rd);
    if (rd[15:0] !== value)
      sb.report_mismatch($sformatf("hold_threshold reads %h, want %h", rd[15:0], value));
    sb.thr = value;
  endtask

  initial begin : stimulus
    logic [31:0] rd;
    logic [15:0] mid_thr;
    int          n, guard;
    sb = new;
    sb.power_up();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    apb_access(1'b0, THR_ADDR, 32'd0, rd);
    if (rd[15:0] !== HOLD_THR_RESET)
      sb.report_mismatch($sformatf("hold_threshold after reset %h", rd[15:0]));

    // sender idles a third of the time, receiver more than half
    tx_idle_pct = 33;
    rx_idle_pct = 59;
    for (n = 0; n < 24; n++) send_sample(fpd_in_t'(PROBES[n]));
    run_random(PHASE_ITEMS, -1, -1);

    // every difference after the first is held; long receiver hold-off midway
    program_threshold(16'd0);
    run_random(PHASE_ITEMS, -1, 120);

    tx_idle_pct = 59;
    rx_idle_pct = 33;
    program_threshold(16'hFFFF);   // above a half turn: nothing is held
    run_random(PHASE_ITEMS, -1, -1);
    program_threshold(16'd32768);  // only exact half turns are held
    run_random(PHASE_ITEMS, -1, -1);

    // back to back; the sender pauses once until the pipe is empty
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_threshold(16'd1);
    run_random(PHASE_ITEMS, 100, -1);
    mid_thr = 16'($urandom_range(16000, 200));
    program_threshold(mid_thr);    // random mid-range threshold
    run_random(PHASE_ITEMS, -1, -1);

    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d expected results never came", sb.pending.size()));

    $display("run: %0d samples in, %0d results checked, %0d held differences, %0d frame ends",
             sb.samples, sb.results, sb.holds, sb.frames);
    $display("run: hold thresholds 5461, 0, 65535, 32768, 1, %0d; %0d mismatches",
             mid_thr, sb.errors);
    if (sb.errors == 0) begin
      $display("** fsk_phase_discriminator_window_core: PASSED **");
    end else begin
      $display("** fsk_phase_discriminator_window_core: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("** fsk_phase_discriminator_window_core: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
src/fpd_pkg.sv
src/fpd_ctrl.sv
src/fpd_datapath.sv
src/fsk_phase_discriminator_window_core.sv
src/fpd_checker.sv
dv/fsk_phase_discriminator_window_core_test.sv
